// ===== sv/kcv_pkg.sv =====
// Shared constants, register indexes and operation codes for the constant-velocity
// position filter. No dependencies.
package kcv_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int CfgWidth  = 32;
   localparam int IoWidth   = 32;

   typedef enum logic [2:0] {
      REG_STEP_TIME      = 3'd0,
      REG_POSITION_NOISE = 3'd1,
      REG_VELOCITY_NOISE = 3'd2,
      REG_MEASURE_NOISE  = 3'd3,
      REG_START_POSITION = 3'd4,
      REG_START_VELOCITY = 3'd5,
      REG_START_VARIANCE = 3'd6
   } reg_index_type;

   localparam logic [30:0] StepTimeReset      = 31'd1311;
   localparam logic [30:0] PositionNoiseReset = 31'd65536;
   localparam logic [30:0] VelocityNoiseReset = 31'd196608;
   localparam logic [30:0] MeasureNoiseReset  = 31'd655360;
   localparam logic [31:0] StartPositionReset = 32'd0;
   localparam logic [31:0] StartVelocityReset = 32'd1310720;
   localparam logic [30:0] StartVarianceReset = 31'd327680;

   // operation codes of the shared unit
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2
   } alu_op_type;

endpackage

// ===== sv/kcv_alu.sv =====
// Shared fixed-point unit: saturating add/sub and Q-format multiply, one op per cycle.
// Depends on kcv_pkg.
module kcv_alu #(
   parameter int DATA_WIDTH = kcv_pkg::DataWidth,
   parameter int FRAC_BITS  = kcv_pkg::FracBits
) (
   input  logic                         clock,
   input  kcv_pkg::alu_op_type          op,
   input  logic signed [DATA_WIDTH-1:0] a,
   input  logic signed [DATA_WIDTH-1:0] b,
   output logic signed [DATA_WIDTH-1:0] result
);
   import kcv_pkg::*;

   localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [DATA_WIDTH:0]       sum;
   logic        [DATA_WIDTH-1:0]     mag_a;
   logic        [DATA_WIDTH-1:0]     mag_b;
   logic        [2*DATA_WIDTH-1:0]   prod;
   logic        [2*DATA_WIDTH-1:0]   shifted;
   logic                             neg;
   logic                             big;
   logic        [DATA_WIDTH-1:0]     mag;
   logic signed [DATA_WIDTH-1:0]     result_in;
   logic signed [DATA_WIDTH-1:0]     result_ff;

   always_comb begin
      sum     = '0;
      mag_a   = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : a;
      mag_b   = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : b;
      prod    = mag_a * mag_b;
      shifted = prod >> FRAC_BITS;
      neg     = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      big     = (shifted[2*DATA_WIDTH-1:DATA_WIDTH] != '0) ||
                (shifted[DATA_WIDTH-1:0] > {1'b1, {(DATA_WIDTH-1){1'b0}}});
      mag     = big ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : shifted[DATA_WIDTH-1:0];
      unique case (op)
         OP_ADD: begin
            sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
            result_in = (sum[DATA_WIDTH] != sum[DATA_WIDTH-1])
                        ? (sum[DATA_WIDTH] ? MinVal : MaxVal) : sum[DATA_WIDTH-1:0];
         end
         OP_SUB: begin
            sum = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
            result_in = (sum[DATA_WIDTH] != sum[DATA_WIDTH-1])
                        ? (sum[DATA_WIDTH] ? MinVal : MaxVal) : sum[DATA_WIDTH-1:0];
         end
         OP_MUL: begin
            if (neg) result_in = DATA_WIDTH'(-mag);
            else if (mag[DATA_WIDTH-1]) result_in = MaxVal;
            else result_in = mag;
         end
         default: result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end
   assign result = result_ff;
endmodule

// ===== sv/kcv_div.sv =====
// Restoring divider, one quotient bit per cycle, for the gain (num << FRAC_BITS) / den.
// Depends on kcv_pkg.
module kcv_div #(
   parameter int DATA_WIDTH = kcv_pkg::DataWidth,
   parameter int FRAC_BITS  = kcv_pkg::FracBits
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] num,
   input  logic signed [DATA_WIDTH-1:0] den,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] quot
);
   import kcv_pkg::*;

   localparam int QW = DATA_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);
   localparam logic [QW-1:0] Limit = QW'({1'b0, {(DATA_WIDTH-1){1'b1}}});

   logic [QW-1:0]         dividend_ff, dividend_in;
   logic [QW-1:0]         q_ff, q_in;
   logic [DATA_WIDTH:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH-1:0] mag_n;

   always_comb begin
      mag_n       = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : num;
      dividend_in = dividend_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      trial       = {rem_ff[DATA_WIDTH-1:0], dividend_ff[QW-1]};
      if (start) begin
         dividend_in = {mag_n, {FRAC_BITS{1'b0}}};
         q_in        = '0;
         rem_in      = '0;
         den_in      = (den < 1) ? DATA_WIDTH'(1) : den;
         neg_in      = num[DATA_WIDTH-1];
         cnt_in      = CW'(QW);
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         dividend_in = dividend_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dividend_ff <= dividend_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
   end

   // quotient beyond the positive range saturates to the signed limit
   always_comb begin
      if (q_ff > Limit) quot = neg_ff ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                      : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else quot = neg_ff ? DATA_WIDTH'(-q_ff[DATA_WIDTH-1:0]) : q_ff[DATA_WIDTH-1:0];
   end
   assign done = done_ff;
endmodule

// ===== sv/kalman_cv_position_filter.sv =====
// Constant-velocity position filter: sequencer, state registers and config port.
// From accept to rsp_tvalid it runs two serial divisions and 22 ops of the shared unit.
// One transaction at a time; not ready while an item is in work or its result waits.
// Reset (synchronous) restores register defaults and reloads the state; any valid
// register write reloads the state too. Depends on kcv_pkg, kcv_alu, kcv_div.
module kalman_cv_position_filter #(
   parameter int DATA_WIDTH = kcv_pkg::DataWidth,
   parameter int FRAC_BITS  = kcv_pkg::FracBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kcv_pkg::IoWidth-1:0]      req_tdata,   // measured_position
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [2*kcv_pkg::IoWidth-1:0]    rsp_tdata,   // filtered_position, filtered_velocity
   input  logic                             csr_we,
   input  logic [2:0]                       csr_index,
   input  logic [kcv_pkg::CfgWidth-1:0]     csr_wdata
);
   import kcv_pkg::*;

   localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_WAIT, S_DIV, S_DIVWAIT, S_OUT
   } state_type;

   typedef enum logic [4:0] {
      T_PP01A, T_PP01, T_P0A, T_P0B, T_P0C, T_P0D, T_PP00, T_PP11, T_XPA, T_XP0,
      T_S, T_K0, T_K1, T_E, T_PE, T_XPOS, T_VE, T_XVEL, T_PV0, T_VPOS, T_PC0,
      T_VCROSS, T_PV1, T_VVEL
   } step_type;

   // config registers
   logic [30:0] dt_ff, q0_ff, q1_ff, rn_ff, var0_ff;
   logic [31:0] pos0_ff, vel0_ff;

   state_type state_ff;
   step_type  step_ff;
   logic signed [DATA_WIDTH-1:0] xpos_ff, xvel_ff, p00_ff, p01_ff, p11_ff;
   logic signed [DATA_WIDTH-1:0] z_ff, t_ff, pp01_ff, pp00_ff, pp11_ff, xp0_ff;
   logic signed [DATA_WIDTH-1:0] s_ff, k0_ff, k1_ff, e_ff;
   logic [2*IoWidth-1:0]         rsp_data_ff;
   logic                         div_sel_ff;

   alu_op_type                   alu_op;
   logic signed [DATA_WIDTH-1:0] alu_a, alu_b, alu_res;
   logic                         div_start, div_done;
   logic signed [DATA_WIDTH-1:0] div_q;

   function automatic logic signed [DATA_WIDTH-1:0] sat_s32(input logic [31:0] v);
      logic signed [47:0] w;
      w = 48'(signed'(v));
      if (w > 48'(MaxVal)) sat_s32 = MaxVal;
      else if (w < 48'(MinVal)) sat_s32 = MinVal;
      else sat_s32 = DATA_WIDTH'(w);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_u31(input logic [30:0] v);
      if (48'(v) > 48'(MaxVal)) sat_u31 = MaxVal;
      else sat_u31 = DATA_WIDTH'(v);
   endfunction

   function automatic logic [IoWidth-1:0] to_io(input logic signed [DATA_WIDTH-1:0] v);
      logic signed [47:0] w;
      w = 48'(v);
      if (w > 48'sh7FFFFFFF) to_io = 32'h7FFFFFFF;
      else if (w < -48'sh80000000) to_io = 32'h80000000;
      else to_io = w[IoWidth-1:0];
   endfunction

   kcv_alu #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
      .clock(clock), .op(alu_op), .a(alu_a), .b(alu_b), .result(alu_res));

   kcv_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_sel_ff ? pp01_ff : pp00_ff), .den(s_ff),
      .done(div_done), .quot(div_q));

   logic signed [DATA_WIDTH-1:0] dt_s, q0_s, q1_s, rn_s;
   assign dt_s = sat_u31(dt_ff);
   assign q0_s = sat_u31(q0_ff);
   assign q1_s = sat_u31(q1_ff);
   assign rn_s = sat_u31(rn_ff);

   // operand select per step
   always_comb begin
      alu_op = OP_ADD;
      alu_a  = '0;
      alu_b  = '0;
      unique case (step_ff)
         T_PP01A: begin alu_op = OP_MUL; alu_a = dt_s;    alu_b = p11_ff;  end
         T_PP01:  begin alu_a = p01_ff;  alu_b = t_ff;                      end
         T_P0A:   begin alu_op = OP_MUL; alu_a = dt_s;    alu_b = p01_ff;  end
         T_P0B:   begin alu_a = p00_ff;  alu_b = t_ff;                      end
         T_P0C:   begin alu_op = OP_MUL; alu_a = dt_s;    alu_b = pp01_ff; end
         T_P0D:   begin alu_a = pp00_ff; alu_b = t_ff;                      end
         T_PP00:  begin alu_a = pp00_ff; alu_b = q0_s;                      end
         T_PP11:  begin alu_a = p11_ff;  alu_b = q1_s;                      end
         T_XPA:   begin alu_op = OP_MUL; alu_a = dt_s;    alu_b = xvel_ff; end
         T_XP0:   begin alu_a = xpos_ff; alu_b = t_ff;                      end
         T_S:     begin alu_a = pp00_ff; alu_b = rn_s;                      end
         T_K0, T_K1: begin end
         T_E:     begin alu_op = OP_SUB; alu_a = z_ff;    alu_b = xp0_ff;  end
         T_PE:    begin alu_op = OP_MUL; alu_a = k0_ff;   alu_b = e_ff;    end
         T_XPOS:  begin alu_a = xp0_ff;  alu_b = t_ff;                      end
         T_VE:    begin alu_op = OP_MUL; alu_a = k1_ff;   alu_b = e_ff;    end
         T_XVEL:  begin alu_a = xvel_ff; alu_b = t_ff;                      end
         T_PV0:   begin alu_op = OP_MUL; alu_a = k0_ff;   alu_b = pp00_ff; end
         T_VPOS:  begin alu_op = OP_SUB; alu_a = pp00_ff; alu_b = t_ff;    end
         T_PC0:   begin alu_op = OP_MUL; alu_a = k0_ff;   alu_b = pp01_ff; end
         T_VCROSS: begin alu_op = OP_SUB; alu_a = pp01_ff; alu_b = t_ff;   end
         T_PV1:   begin alu_op = OP_MUL; alu_a = k1_ff;   alu_b = pp01_ff; end
         T_VVEL:  begin alu_op = OP_SUB; alu_a = pp11_ff; alu_b = t_ff;    end
         default: begin end
      endcase
   end

   assign div_start = (state_ff == S_DIV);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= T_PP01A;
         dt_ff    <= StepTimeReset;
         q0_ff    <= PositionNoiseReset;
         q1_ff    <= VelocityNoiseReset;
         rn_ff    <= MeasureNoiseReset;
         pos0_ff  <= StartPositionReset;
         vel0_ff  <= StartVelocityReset;
         var0_ff  <= StartVarianceReset;
         xpos_ff  <= sat_s32(StartPositionReset);
         xvel_ff  <= sat_s32(StartVelocityReset);
         p00_ff   <= sat_u31(StartVarianceReset);
         p01_ff   <= '0;
         p11_ff   <= sat_u31(StartVarianceReset);
         div_sel_ff <= 1'b0;
      end else if (csr_we && csr_index <= REG_START_VARIANCE) begin
         // register write (user rule, only while idle; unchecked): update and reload the state
         unique case (reg_index_type'(csr_index))
            REG_STEP_TIME:      dt_ff   <= csr_wdata[30:0];
            REG_POSITION_NOISE: q0_ff   <= csr_wdata[30:0];
            REG_VELOCITY_NOISE: q1_ff   <= csr_wdata[30:0];
            REG_MEASURE_NOISE:  rn_ff   <= csr_wdata[30:0];
            REG_START_POSITION: pos0_ff <= csr_wdata;
            REG_START_VELOCITY: vel0_ff <= csr_wdata;
            REG_START_VARIANCE: var0_ff <= csr_wdata[30:0];
            default: begin end
         endcase
         xpos_ff <= (csr_index == REG_START_POSITION) ? sat_s32(csr_wdata) : sat_s32(pos0_ff);
         xvel_ff <= (csr_index == REG_START_VELOCITY) ? sat_s32(csr_wdata) : sat_s32(vel0_ff);
         p00_ff  <= (csr_index == REG_START_VARIANCE) ? sat_u31(csr_wdata[30:0])
                                                      : sat_u31(var0_ff);
         p11_ff  <= (csr_index == REG_START_VARIANCE) ? sat_u31(csr_wdata[30:0])
                                                      : sat_u31(var0_ff);
         p01_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  z_ff     <= sat_s32(req_tdata);
                  step_ff  <= T_PP01A;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: state_ff <= S_WAIT;
            S_WAIT: begin
               // alu result of the issued step is now in alu_res
               state_ff <= S_ISSUE;
               unique case (step_ff)
                  T_PP01A, T_P0A, T_P0C, T_XPA, T_PE, T_VE, T_PV0, T_PC0, T_PV1:
                     t_ff <= alu_res;
                  T_PP01: pp01_ff <= alu_res;
                  T_P0B, T_P0D, T_PP00: pp00_ff <= alu_res;
                  T_PP11: pp11_ff <= alu_res;
                  T_XP0:  xp0_ff  <= alu_res;
                  T_S: begin
                     s_ff       <= alu_res;
                     div_sel_ff <= 1'b0;
                     state_ff   <= S_DIV;
                  end
                  T_E:     e_ff    <= alu_res;
                  T_XPOS:  xpos_ff <= alu_res;
                  T_XVEL:  xvel_ff <= alu_res;
                  T_VPOS:  p00_ff  <= alu_res;
                  T_VCROSS: p01_ff <= alu_res;
                  T_VVEL: begin
                     p11_ff      <= alu_res;
                     rsp_data_ff <= {to_io(xvel_ff), to_io(xpos_ff)};
                     state_ff    <= S_OUT;
                  end
                  default: begin end
               endcase
               if (step_ff == T_PP00) step_ff <= T_PP11;
               else if (step_ff != T_VVEL && step_ff != T_S) step_ff <= step_type'(step_ff + 1'b1);
               else if (step_ff == T_S) step_ff <= T_K0;
            end
            S_DIV: state_ff <= S_DIVWAIT;
            S_DIVWAIT: begin
               if (div_done) begin
                  if (!div_sel_ff) begin
                     k0_ff      <= div_q;
                     div_sel_ff <= 1'b1;
                     step_ff    <= T_K1;
                     state_ff   <= S_DIV;
                  end else begin
                     k1_ff    <= div_q;
                     step_ff  <= T_E;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = rsp_data_ff;
endmodule
